// ===== sv/fcta_pkg.sv =====
// Shared types and constants of the FAT cluster table allocator.
package fcta_pkg;

  localparam int TABLE_ENTRIES_DEF = 4096;
  localparam int OP_W = 2;
  localparam int CLUSTER_W = 12;
  localparam int VALUE_W = 28;
  localparam int STATUS_W = 2;
  localparam int COUNT_W = 12;
  localparam int HINT_W = 13;

  localparam logic [VALUE_W-1:0] END_OF_CHAIN = 28'h0FFF_FFFF;
  localparam logic [COUNT_W-1:0] COUNT_RESET = 12'd4094;
  localparam logic [HINT_W-1:0] HINT_RESET = 13'd2;
  localparam logic [HINT_W-1:0] FIRST_DATA = 13'd2;

  typedef enum logic [OP_W-1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_ALLOC = 2'd2,
    OP_LINK  = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_RANGE = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    KIND_READ,
    KIND_WRITE,
    KIND_ALLOC,
    KIND_RANGE
  } kind_t;

  // One classified request as it waits between front and back.
  typedef struct packed {
    kind_t                kind;
    logic                 link;
    logic [CLUSTER_W-1:0] cluster;
    logic [VALUE_W-1:0]   value;
  } req_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_SCAN,
    S_LINK
  } state_t;

endpackage

// ===== sv/fcta_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module fcta_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/fcta_front.sv =====
// Request front end: range check, classification and a two-entry queue.
module fcta_front
  import fcta_pkg::*;
#(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 hold,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [OP_W-1:0]      operation,
  input  logic [CLUSTER_W-1:0] cluster,
  input  logic [VALUE_W-1:0]   entry_value,
  output logic                 q_valid,
  output req_t                 q_item,
  input  logic                 q_pop
);

  req_t       cls;
  logic       in_range;
  logic       push;
  req_t       slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;

  assign in_range = 32'(cluster) < TABLE_ENTRIES;

  always_comb begin
    cls.cluster = cluster;
    cls.value   = entry_value;
    cls.link    = 1'b0;
    unique case (op_t'(operation))
      OP_READ:  cls.kind = in_range ? KIND_READ : KIND_RANGE;
      OP_WRITE: cls.kind = in_range ? KIND_WRITE : KIND_RANGE;
      OP_ALLOC: cls.kind = KIND_ALLOC;
      OP_LINK: begin
        cls.kind = in_range ? KIND_ALLOC : KIND_RANGE;
        cls.link = 1'b1;
      end
      default:  cls.kind = KIND_RANGE;
    endcase
  end

  // Hold off requests while the table is being cleared.
  assign in_ready = !hold && (fill != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = fill != 2'd0;
  assign q_item   = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({push, q_pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

  ap_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid) else $error("pop from empty request queue");

  ap_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= 2'd2) else $error("request queue overfilled");

  ap_no_push_hold: assert property (@(posedge clk) disable iff (rst)
    hold |-> !push) else $error("request taken during table clear");

endmodule

// ===== sv/fcta_back.sv =====
// Request back end: table store, clearing pass, next-fit scan and result register.
module fcta_back
  import fcta_pkg::*;
#(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [COUNT_W-1:0]  cluster_count,
  input  logic                q_valid,
  input  req_t                q_item,
  output logic                q_pop,
  output logic                clearing,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [VALUE_W-1:0]  result_value,
  output logic [STATUS_W-1:0] status
);

  localparam int AW = $clog2(TABLE_ENTRIES);
  localparam logic [AW-1:0] LAST_ADDR = AW'(TABLE_ENTRIES - 1);

  state_t              state, state_next;
  logic [HINT_W-1:0]   hint, hint_next;
  logic [AW-1:0]       clr_addr;
  logic [HINT_W-1:0]   scan_cur, scan_cur_next;
  logic [HINT_W-1:0]   scan_end, scan_end_next;
  logic [HINT_W-1:0]   alt_end, alt_end_next;
  logic                scan_ph2, scan_ph2_next;
  logic                link, link_next;
  logic [CLUSTER_W-1:0] link_cl, link_cl_next;
  logic                out_valid_next;
  logic [VALUE_W-1:0]  result_next;
  logic [STATUS_W-1:0] status_next;

  logic                mem_we;
  logic [AW-1:0]       mem_waddr;
  logic [VALUE_W-1:0]  mem_wdata;
  logic [AW-1:0]       mem_raddr;
  logic [VALUE_W-1:0]  mem_rdata;

  logic                out_free;
  logic                start;
  logic [31:0]         lim_wide;
  logic [HINT_W-1:0]   lim;
  logic                ph1_ok;
  logic [HINT_W-1:0]   ph2_end;
  logic                ph2_ok;
  logic                found;
  logic [HINT_W-1:0]   cand;
  logic                cand_ok;
  logic                ph2_go;

  // Only the low 28 bits of every entry are stored; the reserved top bits are not kept.
  fcta_ram #(
    .WIDTH(VALUE_W),
    .DEPTH(TABLE_ENTRIES)
  ) u_table (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  assign clearing = state == S_CLEAR;
  assign out_free = !out_valid || out_ready;
  assign start    = (state == S_IDLE) && q_valid && out_free;
  assign q_pop    = start;

  assign lim_wide = 32'(cluster_count) + 32'd2;
  assign lim      = (lim_wide > TABLE_ENTRIES) ? HINT_W'(TABLE_ENTRIES) : HINT_W'(lim_wide);
  assign ph1_ok   = hint < lim;
  assign ph2_end  = ph1_ok ? hint : lim;
  assign ph2_ok   = FIRST_DATA < ph2_end;

  assign found    = mem_rdata == '0;
  assign cand     = scan_cur + 13'd1;
  assign cand_ok  = cand < scan_end;
  assign ph2_go   = !scan_ph2 && (FIRST_DATA < alt_end);

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        if (clr_addr == LAST_ADDR) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          case (q_item.kind)
            KIND_READ:  state_next = S_READ;
            KIND_ALLOC: state_next = (ph1_ok || ph2_ok) ? S_SCAN : S_IDLE;
            default:    state_next = S_IDLE;
          endcase
        end
      end
      S_READ: state_next = S_IDLE;
      S_SCAN: begin
        if (found) begin
          state_next = link ? S_LINK : S_IDLE;
        end else if (!cand_ok && !ph2_go) begin
          state_next = S_IDLE;
        end
      end
      S_LINK: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    mem_we         = 1'b0;
    mem_waddr      = AW'(scan_cur);
    mem_wdata      = END_OF_CHAIN;
    mem_raddr      = AW'(cand);
    hint_next      = hint;
    scan_cur_next  = scan_cur;
    scan_end_next  = scan_end;
    alt_end_next   = alt_end;
    scan_ph2_next  = scan_ph2;
    link_next      = link;
    link_cl_next   = link_cl;
    out_valid_next = out_valid && !out_ready;
    result_next    = result_value;
    status_next    = status;
    unique case (state)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr;
        mem_wdata = '0;
      end
      S_IDLE: begin
        mem_raddr = AW'(q_item.cluster);
        if (start) begin
          link_next    = q_item.link;
          link_cl_next = q_item.cluster;
          case (q_item.kind)
            KIND_WRITE: begin
              mem_we         = 1'b1;
              mem_waddr      = AW'(q_item.cluster);
              mem_wdata      = q_item.value;
              out_valid_next = 1'b1;
              result_next    = '0;
              status_next    = STAT_OK;
            end
            KIND_RANGE: begin
              out_valid_next = 1'b1;
              result_next    = '0;
              status_next    = STAT_RANGE;
            end
            KIND_ALLOC: begin
              alt_end_next = ph2_end;
              if (ph1_ok) begin
                mem_raddr     = AW'(hint);
                scan_cur_next = hint;
                scan_end_next = lim;
                scan_ph2_next = 1'b0;
              end else if (ph2_ok) begin
                mem_raddr     = AW'(FIRST_DATA);
                scan_cur_next = FIRST_DATA;
                scan_end_next = ph2_end;
                scan_ph2_next = 1'b1;
              end else begin
                out_valid_next = 1'b1;
                result_next    = '0;
                status_next    = STAT_FULL;
              end
            end
            default: ;
          endcase
        end
      end
      S_READ: begin
        out_valid_next = 1'b1;
        result_next    = mem_rdata;
        status_next    = STAT_OK;
      end
      S_SCAN: begin
        if (found) begin
          // Mark end of chain; hold scan_cur as the allocated cluster.
          mem_we    = 1'b1;
          hint_next = cand;
          if (!link) begin
            out_valid_next = 1'b1;
            result_next    = VALUE_W'(scan_cur);
            status_next    = STAT_OK;
          end
        end else if (cand_ok) begin
          scan_cur_next = cand;
        end else if (ph2_go) begin
          // Wrap around: scan from the first data cluster up to the old hint.
          mem_raddr     = AW'(FIRST_DATA);
          scan_cur_next = FIRST_DATA;
          scan_end_next = alt_end;
          scan_ph2_next = 1'b1;
        end else begin
          out_valid_next = 1'b1;
          result_next    = '0;
          status_next    = STAT_FULL;
        end
      end
      S_LINK: begin
        mem_we         = 1'b1;
        mem_waddr      = AW'(link_cl);
        mem_wdata      = VALUE_W'(scan_cur);
        out_valid_next = 1'b1;
        result_next    = VALUE_W'(scan_cur);
        status_next    = STAT_OK;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      hint      <= HINT_RESET;
      clr_addr  <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      hint      <= hint_next;
      out_valid <= out_valid_next;
      if (state == S_CLEAR) begin
        clr_addr <= clr_addr + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    scan_cur     <= scan_cur_next;
    scan_end     <= scan_end_next;
    alt_end      <= alt_end_next;
    scan_ph2     <= scan_ph2_next;
    link         <= link_next;
    link_cl      <= link_cl_next;
    result_value <= result_next;
    status       <= status_next;
  end

  ap_scan_in_bounds: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (scan_cur < scan_end)) else $error("scan address past its end");

  ap_hint_range: assert property (@(posedge clk) disable iff (rst)
    (hint >= HINT_RESET) && (hint <= 13'd4097)) else $error("free hint out of range");

  ap_pop_slot_free: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> out_free) else $error("request started with result slot busy");

  ap_full_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status != STAT_OK)) |-> (result_value == '0))
    else $error("nonzero value on failed request");

endmodule

// ===== sv/fat_cluster_table_allocator_unit.sv =====
// Top level of the FAT cluster table allocator: config register, front end and back end.
//
//  channel   signals                                      direction
//  request   in_valid/in_ready, operation, cluster,        in
//            entry_value
//  result    out_valid/out_ready, result_value, status     out
//  config    cfg_we, cfg_data (cluster_count)              in
//
// Write and out-of-range requests are answered straight from the idle state; reads
// pass through the read state first. Allocation examines one table entry at a time (one
// table read port) and passes through the link state when linking; a full table costs the whole scan.
// After reset the back end clears the table, with in_ready low.
// A two-entry queue keeps taking requests, until it is full, while the back end scans
// or a result waits in the output register.
module fat_cluster_table_allocator_unit
  import fcta_pkg::*;
#(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [COUNT_W-1:0]   cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [OP_W-1:0]      operation,
  input  logic [CLUSTER_W-1:0] cluster,
  input  logic [VALUE_W-1:0]   entry_value,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [VALUE_W-1:0]   result_value,
  output logic [STATUS_W-1:0]  status
);

  logic [COUNT_W-1:0] cluster_count;
  logic               q_valid;
  req_t               q_item;
  logic               q_pop;
  logic               clearing;

  always_ff @(posedge clk) begin
    if (rst) begin
      cluster_count <= COUNT_RESET;
    end else if (cfg_we) begin
      cluster_count <= cfg_data;
    end
  end

  fcta_front #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .hold       (clearing),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .operation  (operation),
    .cluster    (cluster),
    .entry_value(entry_value),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_pop      (q_pop)
  );

  fcta_back #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .cluster_count(cluster_count),
    .q_valid      (q_valid),
    .q_item       (q_item),
    .q_pop        (q_pop),
    .clearing     (clearing),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .result_value (result_value),
    .status       (status)
  );

endmodule

// ===== dv/tb_fat_cluster_table_allocator_unit.sv =====
// Self-checking testbench for the FAT cluster table allocator: shadow table, random traffic.
module tb_fat_cluster_table_allocator_unit;
  import fcta_pkg::*;

  localparam int TBL_N = TABLE_ENTRIES_DEF;
  localparam int PHASES = 12;
  localparam int PHASE_REQS = 160;
  localparam int HOLD_CYCLES = 300;
  localparam int STALL_LIMIT = 40000;

  typedef struct {
    op_t                  op;
    logic [CLUSTER_W-1:0] cl;
    logic [VALUE_W-1:0]   val;
  } fat_cmd_t;

  typedef struct {
    logic [VALUE_W-1:0] value;
    status_t            st;
  } fat_reply_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_we = 1'b0;
  logic [COUNT_W-1:0]   cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [OP_W-1:0]      operation = '0;
  logic [CLUSTER_W-1:0] cluster = '0;
  logic [VALUE_W-1:0]   entry_value = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [VALUE_W-1:0]   result_value;
  logic [STATUS_W-1:0]  status;

  // Shadow copy of the block state
  logic [31:0]        shadow_table [TBL_N];
  logic [HINT_W-1:0]  shadow_hint;
  logic [COUNT_W-1:0] shadow_count;

  fat_cmd_t   req_backlog [$];
  fat_reply_t owed_replies [$];

  int send_idle_pct = 10;
  int recv_idle_pct = 53;
  bit hold_armed = 1'b0;
  bit hold_taken;
  int hold_left;
  int stall_cycles;
  int fail_count = 0;
  int phase_count [PHASES] = '{4094, 3, 0, 17, 4095, 60, 2, 1, 200, 9, 4094, 4095};

  fat_cluster_table_allocator_unit u_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .operation    (operation),
    .cluster      (cluster),
    .entry_value  (entry_value),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .result_value (result_value),
    .status       (status)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Keep the reserved top bits, replace the low 28
  function automatic void shadow_put(int idx, logic [VALUE_W-1:0] v);
    shadow_table[idx] = {shadow_table[idx][31:VALUE_W], v};
  endfunction

  // Next-fit scan: hint up to the limit, then wrap from the first data cluster
  function automatic logic [VALUE_W-1:0] shadow_grab();
    int lim;
    int h;
    int c;
    int stop;
    lim = int'(shadow_count) + 2;
    if (lim > TBL_N) lim = TBL_N;
    h = int'(shadow_hint);
    for (c = h; c < lim; c++) begin
      if (shadow_table[c][VALUE_W-1:0] == '0) begin
        shadow_put(c, END_OF_CHAIN);
        shadow_hint = HINT_W'(c + 1);
        return VALUE_W'(c);
      end
    end
    stop = (h < lim) ? h : lim;
    for (c = int'(FIRST_DATA); c < stop; c++) begin
      if (shadow_table[c][VALUE_W-1:0] == '0) begin
        shadow_put(c, END_OF_CHAIN);
        shadow_hint = HINT_W'(c + 1);
        return VALUE_W'(c);
      end
    end
    return '0;
  endfunction

  function automatic fat_reply_t shadow_serve(op_t op, logic [CLUSTER_W-1:0] cl,
                                              logic [VALUE_W-1:0] val);
    fat_reply_t r;
    logic [VALUE_W-1:0] got;
    r.value = '0;
    r.st = STAT_OK;
    if (op != OP_ALLOC && int'(cl) >= TBL_N) begin
      r.st = STAT_RANGE;
    end else begin
      case (op)
        OP_READ: r.value = shadow_table[cl][VALUE_W-1:0];
        OP_WRITE: shadow_put(int'(cl), val);
        default: begin
          got = shadow_grab();
          if (got == '0) begin
            r.st = STAT_FULL;
          end else begin
            r.value = got;
            // link write lands last, so a self link overwrites the end mark
            if (op == OP_LINK) shadow_put(int'(cl), got);
          end
        end
      endcase
    end
    return r;
  endfunction

  // Driver: hold each request until accepted, then advance
  always @(posedge clk) begin : drive
    fat_cmd_t cmd;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (req_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        cmd = req_backlog.pop_front();
        in_valid <= 1'b1;
        operation <= cmd.op;
        cluster <= cmd.cl;
        entry_value <= cmd.val;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls plus one long hold-off
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      hold_left <= 0;
      hold_taken <= 1'b0;
    end else if (hold_armed && !hold_taken) begin
      hold_taken <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Monitor: check results first, then predict the request taken at this edge
  always @(posedge clk) begin : watch
    fat_reply_t want;
    if (rst) begin
      for (int i = 0; i < TBL_N; i++) shadow_table[i] = '0;
      shadow_hint = HINT_RESET;
      shadow_count = COUNT_RESET;
    end else begin
      if (cfg_we) shadow_count = cfg_data;
      if (out_valid && out_ready) begin
        if (owed_replies.size() == 0) begin
          $error("unexpected result: result_value %0h status %0d", result_value, status);
          fail_count++;
        end else begin
          want = owed_replies.pop_front();
          if (result_value !== want.value) begin
            $error("result_value: expected %0h, got %0h", want.value, result_value);
            fail_count++;
          end
          if (status !== want.st) begin
            $error("status: expected %0d, got %0d", want.st, status);
            fail_count++;
          end
        end
      end
      if (in_valid && in_ready)
        owed_replies.push_back(shadow_serve(op_t'(operation), cluster, entry_value));
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("[fat_cluster_table_allocator_unit] ERROR");
        $finish;
      end
    end
  end

  task automatic push_cmd(op_t op, int cl, logic [VALUE_W-1:0] val);
    fat_cmd_t cmd;
    cmd.op = op;
    cmd.cl = CLUSTER_W'(cl);
    cmd.val = val;
    req_backlog.push_back(cmd);
  endtask

  function automatic fat_cmd_t rand_cmd(int span);
    fat_cmd_t cmd;
    int pick;
    cmd.op = op_t'($urandom_range(3));
    if ($urandom_range(9) < 7) cmd.cl = CLUSTER_W'($urandom_range(span));
    else cmd.cl = CLUSTER_W'($urandom_range(TBL_N - 1));
    pick = $urandom_range(9);
    if (pick < 3) cmd.val = '0;
    else if (pick == 3) cmd.val = END_OF_CHAIN;
    else cmd.val = VALUE_W'($urandom);
    return cmd;
  endfunction

  // Wait until no request is pending and every result is in
  task automatic settle();
    while (req_backlog.size() != 0 || in_valid || owed_replies.size() != 0)
      @(negedge clk);
  endtask

  task automatic load_count(int v);
    settle();
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= COUNT_W'(v);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  initial begin
    int span;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Fresh table, full count
    load_count(4094);
    push_cmd(OP_READ, 0, '0);
    push_cmd(OP_LINK, 2, '0);
    push_cmd(OP_READ, 2, '0);
    push_cmd(OP_WRITE, TBL_N - 1, END_OF_CHAIN);
    push_cmd(OP_READ, TBL_N - 1, '0);
    push_cmd(OP_WRITE, 0, 28'h5A5_A5A5);
    push_cmd(OP_READ, 0, '0);
    push_cmd(OP_ALLOC, 0, '0);
    push_cmd(OP_LINK, 3, '0);
    push_cmd(OP_WRITE, 5, 28'h000_0001);
    push_cmd(OP_ALLOC, 0, '0);
    push_cmd(OP_READ, 4, '0);
    push_cmd(OP_WRITE, 1, '0);
    push_cmd(OP_READ, 1, '0);

    // Empty count: every allocation reports full, no link written
    load_count(0);
    push_cmd(OP_ALLOC, 0, '0);
    push_cmd(OP_LINK, 7, '0);
    push_cmd(OP_READ, 7, '0);

    // One data cluster: wrap below the hint, then full again
    load_count(1);
    push_cmd(OP_ALLOC, 0, '0);
    push_cmd(OP_WRITE, 2, '0);
    push_cmd(OP_ALLOC, 0, '0);
    push_cmd(OP_ALLOC, 0, '0);
    push_cmd(OP_WRITE, 3, 28'h000_0001);
    push_cmd(OP_READ, 3, '0);

    for (int p = 0; p < PHASES; p++) begin
      load_count(phase_count[p]);
      if (p < 4) begin
        send_idle_pct = 10;
        recv_idle_pct = 53;
      end else if (p < 8) begin
        send_idle_pct = 53;
        recv_idle_pct = 10;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      span = phase_count[p] + 3;
      if (span > TBL_N - 1) span = TBL_N - 1;
      for (int i = 0; i < PHASE_REQS; i++) req_backlog.push_back(rand_cmd(span));
      // Stall the result side long enough to back up the request side
      if (p == 8) hold_armed = 1'b1;
    end

    settle();
    repeat (20) @(posedge clk);
    if (owed_replies.size() != 0) begin
      $error("%0d results never arrived", owed_replies.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("[fat_cluster_table_allocator_unit] OK");
    end else begin
      $display("[fat_cluster_table_allocator_unit] ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/fcta_pkg.sv
sv/fcta_ram.sv
sv/fcta_front.sv
sv/fcta_back.sv
sv/fat_cluster_table_allocator_unit.sv
dv/tb_fat_cluster_table_allocator_unit.sv
